// ----- rtl/pressure_scale_and_debounce_top_defines.svh -----
// Assertion macros shared by the pressure scaling checker.
`ifndef PRESSURE_SCALE_AND_DEBOUNCE_TOP_DEFINES_SVH
`define PRESSURE_SCALE_AND_DEBOUNCE_TOP_DEFINES_SVH

// Property checked at every clock edge, ignored while reset is high.
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/psd_pkg.sv -----
// Shared types and constants of the pressure scaling and debounce block.
`timescale 1ns / 1ps
package psd_pkg;

  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic [2:0] REG_SCALE_GAIN   = 3'd0;
  localparam logic [2:0] REG_SCALE_OFFSET = 3'd1;
  localparam logic [2:0] REG_LIMIT_LOW    = 3'd2;
  localparam logic [2:0] REG_LIMIT_HIGH   = 3'd3;
  localparam logic [2:0] REG_ATMOSPHERE   = 3'd4;
  localparam logic [2:0] REG_CHANGE_COUNT = 3'd5;
  localparam logic [2:0] REG_ERROR_CODE   = 3'd6;
  localparam logic [2:0] REG_ADC_MARKER   = 3'd7;

  localparam logic [7:0] ACCEPTED_RESET = 8'd88;

  typedef struct packed {
    logic        [23:0] scale_gain;
    logic signed [39:0] scale_offset;
    logic signed [31:0] limit_low;
    logic signed [31:0] limit_high;
    logic        [30:0] atmosphere;
    logic        [6:0]  change_count;
    logic        [7:0]  error_code;
    logic        [15:0] adc_error_marker;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_gain:       24'd65536,
    scale_offset:     40'sd0,
    limit_low:        32'sd0,
    limit_high:       32'sd2147483647,
    atmosphere:       31'd0,
    change_count:     7'd2,
    error_code:       8'd255,
    adc_error_marker: 16'd65535
  };

endpackage

// ----- rtl/psd_regs.sv -----
// APB configuration register file of the pressure scaling block.
`timescale 1ns / 1ps
module psd_regs import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  logic [2:0] reg_index;

  assign reg_index = paddr[PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_SCALE_GAIN:   cfg.scale_gain       <= pwdata[23:0];
        REG_SCALE_OFFSET: cfg.scale_offset     <= $signed(pwdata[39:0]);
        REG_LIMIT_LOW:    cfg.limit_low        <= $signed(pwdata[31:0]);
        REG_LIMIT_HIGH:   cfg.limit_high       <= $signed(pwdata[31:0]);
        REG_ATMOSPHERE:   cfg.atmosphere       <= pwdata[30:0];
        REG_CHANGE_COUNT: cfg.change_count     <= pwdata[6:0];
        REG_ERROR_CODE:   cfg.error_code       <= pwdata[7:0];
        REG_ADC_MARKER:   cfg.adc_error_marker <= pwdata[15:0];
      endcase
    end
  end

  // Signed registers read back sign extended.
  always_comb begin
    unique case (reg_index)
      REG_SCALE_GAIN:   prdata = PDATA_W'(cfg.scale_gain);
      REG_SCALE_OFFSET: prdata = PDATA_W'(cfg.scale_offset);
      REG_LIMIT_LOW:    prdata = PDATA_W'(cfg.limit_low);
      REG_LIMIT_HIGH:   prdata = PDATA_W'(cfg.limit_high);
      REG_ATMOSPHERE:   prdata = PDATA_W'(cfg.atmosphere);
      REG_CHANGE_COUNT: prdata = PDATA_W'(cfg.change_count);
      REG_ERROR_CODE:   prdata = PDATA_W'(cfg.error_code);
      REG_ADC_MARKER:   prdata = PDATA_W'(cfg.adc_error_marker);
    endcase
  end

endmodule

// ----- rtl/psd_scale.sv -----
// Pipelined linear scaling of a converter sample to a rounded pressure candidate.
`timescale 1ns / 1ps
module psd_scale import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] adc_sample,
  output logic        cand_valid,
  input  logic        cand_ready,
  output logic [7:0]  cand
);

  logic               s1_valid;
  logic [15:0]        s1_sample;
  logic               s2_valid;
  logic [39:0]        s2_product;
  logic               s2_marker;
  logic               s3_valid;
  logic signed [41:0] s3_scaled;
  logic               s3_marker;

  logic s1_ready, s2_ready, s3_ready, s4_ready;

  logic signed [41:0] scaled_next;
  logic signed [41:0] lim_low, lim_high, atm, atm_adj, rounded;
  logic               sensor_error, above_atm;
  logic [25:0]        whole;
  logic [7:0]         cand_next;

  // Each stage loads when it is empty or its content moves on.
  assign s4_ready = !cand_valid || cand_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign scaled_next = $signed({2'b00, s2_product}) + 42'(cfg.scale_offset);

  assign lim_low   = 42'(cfg.limit_low);
  assign lim_high  = 42'(cfg.limit_high);
  assign atm       = $signed({11'd0, cfg.atmosphere});
  // Atmosphere less the rounding half, so one subtract rounds as well.
  assign atm_adj   = atm - 42'sd32768;

  assign sensor_error = s3_marker || (s3_scaled > lim_high) || (s3_scaled < lim_low);
  assign above_atm    = s3_scaled >= atm;
  assign rounded      = s3_scaled - atm_adj;
  assign whole        = above_atm ? rounded[41:16] : 26'd0;

  always_comb begin
    if (sensor_error) begin
      cand_next = cfg.error_code;
    end else if (|whole[25:8]) begin
      cand_next = 8'hFF;
    end else begin
      cand_next = whole[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      cand_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid   <= in_valid;
      if (s2_ready) s2_valid   <= s1_valid;
      if (s3_ready) s3_valid   <= s2_valid;
      if (s4_ready) cand_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_sample <= adc_sample;
    end
    if (s2_ready && s1_valid) begin
      s2_product <= 40'(s1_sample) * 40'(cfg.scale_gain);
      s2_marker  <= s1_sample == cfg.adc_error_marker;
    end
    if (s3_ready && s2_valid) begin
      s3_scaled <= scaled_next;
      s3_marker <= s2_marker;
    end
    if (s4_ready && s3_valid) begin
      cand <= cand_next;
    end
  end

endmodule

// ----- rtl/pressure_scale_and_debounce_top.sv -----
// Top level of the pressure scaling and direction debounce block.
`timescale 1ns / 1ps
// Throughput: one input transaction per cycle unless back-pressure from the result channel
// stalls the pipeline. Each register (sample, product, scaled sum, candidate, result)
// loads whenever the one after it is empty or is being emptied.
// Reset is synchronous: the pipeline empties, the accepted value returns to 88, the
// direction count to zero and all configuration registers to their documented values.
module pressure_scale_and_debounce_top import psd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Sample channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        adc_sample,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pressure_value,
  output logic               is_error
);

  cfg_t cfg;

  logic              cand_valid;
  logic              cand_ready;
  logic [7:0]        cand;

  // Debounce state.
  logic [7:0]        accepted;
  logic signed [7:0] count;

  logic              take, differ, fire;
  logic signed [7:0] count_next, cc_pos, cc_neg;

  assign pready = 1'b1;

  psd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  psd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .cand       (cand)
  );

  // The candidate is consumed whenever the output register can take a result, so a
  // candidate that produces no transaction never waits on the downstream side longer
  // than a held result does.
  assign cand_ready = !out_valid || out_ready;
  assign take       = cand_valid && cand_ready;

  // A candidate equal to the accepted value leaves the count alone. Otherwise the
  // count moves one step toward the candidate's direction, saturating at +/-127.
  assign differ = cand != accepted;

  always_comb begin
    if (cand > accepted) begin
      count_next = (count == 8'sd127) ? count : count + 8'sd1;
    end else begin
      count_next = (count == -8'sd127) ? count : count - 8'sd1;
    end
  end

  // The change is accepted once the count's magnitude exceeds the configured count.
  assign cc_pos = $signed({1'b0, cfg.change_count});
  assign cc_neg = -cc_pos;
  assign fire   = differ && ((count_next > cc_pos) || (count_next < cc_neg));

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted  <= ACCEPTED_RESET;
      count     <= 8'sd0;
      out_valid <= 1'b0;
    end else begin
      if (take && fire) begin
        accepted <= cand;
        count    <= 8'sd0;
      end else if (take && differ) begin
        count <= count_next;
      end

      if (take && fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The error flag compares the newly accepted value against the error code.
  always_ff @(posedge clk) begin
    if (take && fire) begin
      pressure_value <= cand;
      is_error       <= cand == cfg.error_code;
    end
  end

endmodule

// ----- rtl/psd_checker.sv -----
// Port-level checker for the pressure scaling block and its bind.
`timescale 1ns / 1ps
`include "pressure_scale_and_debounce_top_defines.svh"
module psd_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pressure_value,
  input logic       is_error
);

  // Reset empties the output register and opens the input side.
  `PSD_ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && in_ready), "reset did not empty the block")

  // With no result held, every stage can move, so the input side must be ready.
  `PSD_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

  // A result that is not taken holds its value.
  `PSD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(pressure_value) && $stable(is_error)), "stalled result changed")

  // The configuration port never inserts wait states.
  `PSD_ASSERT(a_pready_high, pready, "pready dropped")

endmodule

bind pressure_scale_and_debounce_top psd_checker u_psd_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the pressure scaling and direction debounce block.
`timescale 1ns / 1ps
module testbench;
  import psd_pkg::*;

  // Cycles without any transaction, while work is still outstanding, before the
  // run is declared hung. The longest deliberate stall is the receiver hold-off.
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  // Cycles allowed after the last expected reading before config is touched or the run
  // ends, so samples that produce no reading can leave the five-stage pipeline.
  localparam int SETTLE_CYCLES = 10;
  localparam longint Q16_HALF = 64'sd32768;

  // Opening sequence under the reset settings (gain 1.0, no offset, change count 2).
  // It walks the accepted value down to zero, up to the converter-fault code, through
  // out-of-limit and saturating samples, a candidate equal to the accepted value that
  // must leave the direction count alone, a reversal, and a saturated value that
  // matches the fault code.
  localparam logic [15:0] OPENING [20] = '{
    16'd0, 16'd0, 16'd0,
    16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'd40000, 16'd300,
    16'd100, 16'd255, 16'd100, 16'd100,
    16'd101, 16'd99, 16'd101, 16'd101, 16'd101,
    16'd32767, 16'd32767, 16'd32767
  };

  typedef struct {
    logic [7:0] pressure;
    logic       error_flag;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        adc_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         pressure_value;
  logic               is_error;

  // Samples waiting to be offered and readings the block still owes us.
  logic [15:0] sample_backlog [$];
  reading_t    expected_readings [$];

  // Local copy of the configuration, kept in plain Q16 integers for the predictor.
  longint     gain_q16 = longint'(CFG_RESET.scale_gain);
  longint     offset_q16 = longint'(CFG_RESET.scale_offset);
  longint     floor_q16 = longint'(CFG_RESET.limit_low);
  longint     ceiling_q16 = longint'(CFG_RESET.limit_high);
  longint     atmosphere_q16 = longint'(CFG_RESET.atmosphere);
  int         change_limit = int'(CFG_RESET.change_count);
  logic [7:0] fault_code = CFG_RESET.error_code;
  logic [15:0] fault_marker = CFG_RESET.adc_error_marker;

  // Predicted debounce state.
  logic [7:0] held_value = ACCEPTED_RESET;
  int         direction_count = 0;

  // Traffic shaping, steered phase by phase from the sequence below.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatch_count = 0;

  pressure_scale_and_debounce_top uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pressure_value (pressure_value),
    .is_error       (is_error)
  );

  always #5 clk = ~clk;

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Scales one sample, runs it through the direction debounce, and queues the
  // reading the block must produce when the debounce accepts a new value.
  function automatic void debounce_sample(input logic [15:0] sample);
    longint     scaled;
    longint     above;
    longint     rounded;
    logic [7:0] candidate;
    reading_t   reading;
    scaled = longint'(sample) * gain_q16 + offset_q16;
    if (sample == fault_marker || scaled > ceiling_q16 || scaled < floor_q16) begin
      candidate = fault_code;
    end else begin
      above = (scaled < atmosphere_q16) ? 64'sd0 : scaled - atmosphere_q16;
      rounded = (above + Q16_HALF) >>> 16;
      candidate = (rounded > 255) ? 8'hFF : rounded[7:0];
    end
    // An unchanged candidate leaves both the value and the count untouched.
    if (candidate == held_value) return;
    if (candidate > held_value) begin
      if (direction_count < 127) direction_count++;
    end else begin
      if (direction_count > -127) direction_count--;
    end
    if (direction_count > change_limit || direction_count < -change_limit) begin
      direction_count = 0;
      held_value = candidate;
      reading.pressure = candidate;
      reading.error_flag = (candidate == fault_code);
      expected_readings.push_back(reading);
    end
  endfunction

  // Sample driver. The prediction is made at the edge where the transaction is
  // accepted, using the sample still on the port.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) debounce_sample(adc_sample);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          in_valid <= 1'b1;
          adc_sample <= sample_backlog.pop_front();
          gap_left = gaps_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reading monitor and receiver back-pressure. A hold request from the sequence
  // turns into one long stretch with ready low while the sender keeps pushing.
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected reading: pressure_value %0d is_error %0d",
                 pressure_value, is_error);
          mismatch_count++;
        end else begin
          want = expected_readings.pop_front();
          if (pressure_value !== want.pressure) begin
            $error("pressure_value: expected %0d, actual %0d", want.pressure, pressure_value);
            mismatch_count++;
          end
          if (is_error !== want.error_flag) begin
            $error("is_error: expected %0d, actual %0d", want.error_flag, is_error);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        hold_left = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Progress counter: cycles with work outstanding but no transaction on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (sample_backlog.size() == 0 && !in_valid && expected_readings.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // One register write: setup cycle, then access cycle until pready. The local copy
  // of the configuration follows at the same moment the block takes the value.
  task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_SCALE_GAIN:   gain_q16 = longint'(value[23:0]);
      REG_SCALE_OFFSET: offset_q16 = longint'($signed(value[39:0]));
      REG_LIMIT_LOW:    floor_q16 = longint'($signed(value[31:0]));
      REG_LIMIT_HIGH:   ceiling_q16 = longint'($signed(value[31:0]));
      REG_ATMOSPHERE:   atmosphere_q16 = longint'(value[30:0]);
      REG_CHANGE_COUNT: change_limit = int'(value[6:0]);
      REG_ERROR_CODE:   fault_code = value[7:0];
      REG_ADC_MARKER:   fault_marker = value[15:0];
      default: ;
    endcase
  endtask

  // Waits until every sample is in and every reading out, then lets the pipeline
  // flush samples that produce nothing.
  task automatic drain();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_valid || expected_readings.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly runs of one sample long enough to get through the debounce, with some
  // lone glitches mixed in. Sample widths vary so candidates spread over the range.
  task automatic queue_random_runs(input int count);
    int          queued;
    int          run_len;
    logic [15:0] sample;
    queued = 0;
    while (queued < count) begin
      case ($urandom_range(0, 9))
        0:       sample = fault_marker;
        1, 2:    sample = 16'($urandom);
        3, 4:    sample = 16'($urandom) & 16'h0FFF;
        default: sample = 16'($urandom) & 16'h00FF;
      endcase
      if ($urandom_range(0, 4) == 0) run_len = 1;
      else run_len = $urandom_range(change_limit + 1, change_limit + 3);
      repeat (run_len) sample_backlog.push_back(sample);
      queued += run_len;
    end
  endtask

  initial begin
    int     low_level;
    int     high_level;
    longint wide;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: hand-picked corner samples, then random runs.
    foreach (OPENING[i]) sample_backlog.push_back(OPENING[i]);
    queue_random_runs(40);
    drain();

    // Every sample flips the value with a change count of zero, so each transaction
    // yields a reading. A half-count offset checks rounding half up, and the
    // receiver holds off long enough for the block to back up into its input.
    write_reg(REG_CHANGE_COUNT, 64'd0);
    write_reg(REG_SCALE_OFFSET, 64'(Q16_HALF));
    write_reg(REG_ATMOSPHERE, 64'd5 << 16);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    low_level = $urandom_range(10, 200);
    high_level = low_level + $urandom_range(1, 50);
    for (int i = 0; i < 60; i++) begin
      sample_backlog.push_back(16'((i % 2) ? high_level : low_level));
    end
    drain();

    // Extreme corner: full gain, most negative offset, widest limits, full
    // atmosphere, slowest debounce, fault code and marker both zero. Every
    // candidate is zero, so a reading only appears after 127 steps downward.
    gaps_on = 1'b1;
    write_reg(REG_SCALE_GAIN, 64'hFF_FFFF);
    write_reg(REG_SCALE_OFFSET, 64'hFFFF_FF80_0000_0000);
    write_reg(REG_LIMIT_LOW, 64'h0000_0000_8000_0000);
    write_reg(REG_LIMIT_HIGH, 64'h0000_0000_7FFF_FFFF);
    write_reg(REG_ATMOSPHERE, 64'h7FFF_FFFF);
    write_reg(REG_CHANGE_COUNT, 64'd126);
    write_reg(REG_ERROR_CODE, 64'd0);
    write_reg(REG_ADC_MARKER, 64'd0);
    sample_backlog.push_back(16'd0);
    sample_backlog.push_back(16'd32768);
    repeat (128) sample_backlog.push_back(16'($urandom));
    drain();

    // Random settings, biased toward mappings that land inside the output range,
    // with the occasional full-width value and phases free of idling.
    repeat (6) begin
      case ($urandom_range(0, 5))
        0:       wide = 0;
        1:       wide = longint'($urandom & 32'h00FF_FFFF);
        default: wide = longint'($urandom_range(1 << 12, 1 << 18));
      endcase
      write_reg(REG_SCALE_GAIN, 64'(wide));
      if ($urandom_range(0, 3) == 0) wide = longint'({$urandom, $urandom});
      else wide = longint'($urandom_range(0, 1 << 27)) - (64'sd1 << 26);
      write_reg(REG_SCALE_OFFSET, 64'(wide));
      if ($urandom_range(0, 3) == 0) wide = longint'($urandom);
      else wide = -longint'($urandom_range(0, 1 << 24));
      write_reg(REG_LIMIT_LOW, 64'(wide));
      if ($urandom_range(0, 3) == 0) wide = longint'($urandom);
      else wide = longint'($urandom_range(1 << 26, 32'h7FFF_FFFF));
      write_reg(REG_LIMIT_HIGH, 64'(wide));
      if ($urandom_range(0, 3) == 0) wide = longint'($urandom & 32'h7FFF_FFFF);
      else wide = longint'($urandom_range(0, 1 << 22));
      write_reg(REG_ATMOSPHERE, 64'(wide));
      write_reg(REG_CHANGE_COUNT, 64'($urandom_range(0, 6)));
      write_reg(REG_ERROR_CODE, 64'($urandom_range(0, 255)));
      write_reg(REG_ADC_MARKER, 64'($urandom & 32'hFFFF));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      queue_random_runs(25);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
